>>> src/baa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baa_pkg
// types, constants and codes shared by the bump arena allocator modules
// ----------------------------------------------------------------------------
package baa_pkg;

  localparam int MARK_DEPTH  = 64;
  localparam int ALIGN_BYTES = 8;

  localparam int DEPTH_W   = $clog2(MARK_DEPTH + 1);
  localparam int MIDX_W    = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int OVF_W     = 16;
  localparam int ADDR_W    = 3;

  localparam logic [OVF_W-1:0]   OVF_MAX     = {OVF_W{1'b1}};
  localparam logic [DEPTH_W-1:0] DEPTH_FULL  = DEPTH_W'(MARK_DEPTH);
  localparam logic [32:0]        ALIGN_ADD   = 33'(ALIGN_BYTES - 1);
  localparam logic [32:0]        ALIGN_MASK  = ~(33'(ALIGN_BYTES - 1));

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_POP   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_OVF   = 2'd2,
    ST_UNDER = 2'd3
  } status_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_BASE     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] request_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] alloc_address;
    logic [31:0] used_bytes;
    logic [6:0]  mark_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic rd;
    logic restore;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_read;
  } dp_stat_t;

endpackage : baa_pkg
`default_nettype wire

>>> src/baa_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baa_cfg
// apb register file holding arena capacity and base address
// ----------------------------------------------------------------------------
module baa_cfg
  import baa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [31:0]       capacity,
  output logic      [31:0]       base
);

  logic [31:0] capacity_r;
  logic [31:0] base_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
      base_r     <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CAPACITY: capacity_r <= pwdata;
        REG_BASE:     base_r     <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CAPACITY: prdata = capacity_r;
      REG_BASE:     prdata = base_r;
      default:      prdata = '0;
    endcase
  end

  assign capacity = capacity_r;
  assign base     = base_r;

endmodule : baa_cfg
`default_nettype wire

>>> src/baa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baa_ctrl
// command sequencer: accept, execute, optional restore from mark memory
// ----------------------------------------------------------------------------
module baa_ctrl
  import baa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESTORE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.needs_read) begin
          cmd.rd    = 1'b1;
          state_nxt = S_RESTORE;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RESTORE: begin
        cmd.restore = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule : baa_ctrl
`default_nettype wire

>>> src/baa_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baa_dpath
// arena datapath: bump pointer, mark memory, overflow count, result register
// ----------------------------------------------------------------------------
module baa_dpath
  import baa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctrl_cmd_t   cmd,
  output dp_stat_t         stat,
  input  wire in_item_t    in_payload,
  input  wire logic [31:0] capacity,
  input  wire logic [31:0] base,
  output logic             out_valid,
  output out_item_t        out_payload
);

  logic [31:0] mem [MARK_DEPTH];

  cmd_t             cmd_r;
  logic [32:0]      rounded_r;
  logic [31:0]      used_r, used_nxt;
  logic [OVF_W-1:0] ovf_r, ovf_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [31:0]      rd_data_r;
  logic             out_valid_r;
  out_item_t        out_r, out_nxt;

  logic [33:0]      fit_sum;
  logic             fits;
  logic             mem_we;
  logic [MIDX_W-1:0] wr_idx;
  logic [MIDX_W-1:0] rd_idx;
  logic [DEPTH_W-1:0] depth_dec;
  status_t          st;
  logic [31:0]      addr;

  assign fit_sum   = {1'b0, used_r} + {1'b0, rounded_r};
  assign fits      = (fit_sum <= {2'b00, capacity});
  assign depth_dec = depth_r - DEPTH_W'(1);
  assign wr_idx    = MIDX_W'(depth_r);
  assign rd_idx    = MIDX_W'(depth_dec);

  assign stat.needs_read = (cmd_r == CMD_POP) && (ovf_r == '0) && (depth_r != '0);

  always_comb begin
    used_nxt  = used_r;
    ovf_nxt   = ovf_r;
    depth_nxt = depth_r;
    mem_we    = 1'b0;
    st        = ST_OK;
    addr      = '0;
    if (cmd.apply) begin
      case (cmd_r)
        CMD_ALLOC: begin
          if (fits) begin
            addr     = base + used_r;
            used_nxt = fit_sum[31:0];
          end else begin
            st = ST_OOM;
          end
        end
        CMD_PUSH: begin
          if (depth_r < DEPTH_FULL) begin
            mem_we    = 1'b1;
            depth_nxt = depth_r + DEPTH_W'(1);
          end else begin
            if (ovf_r != OVF_MAX) ovf_nxt = ovf_r + OVF_W'(1);
            st = ST_OVF;
          end
        end
        CMD_POP: begin
          if (ovf_r != '0) begin
            ovf_nxt = ovf_r - OVF_W'(1);
          end else begin
            st = ST_UNDER;
          end
        end
        CMD_CLEAR: begin
          used_nxt  = '0;
          depth_nxt = '0;
          ovf_nxt   = '0;
        end
        default: ;
      endcase
    end else if (cmd.restore) begin
      used_nxt  = rd_data_r;
      depth_nxt = depth_dec;
    end
    out_nxt.status        = st;
    out_nxt.alloc_address = addr;
    out_nxt.used_bytes    = used_nxt;
    out_nxt.mark_count    = 7'(depth_nxt);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx] <= used_r;
    if (cmd.rd) rd_data_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= cmd_t'(in_payload.command);
      rounded_r <= ({1'b0, in_payload.request_size} + ALIGN_ADD) & ALIGN_MASK;
    end
    if (cmd.apply || cmd.restore) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      ovf_r       <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= cmd.apply || cmd.restore;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule : baa_dpath
`default_nettype wire

>>> src/bump_arena_allocator_with_marks_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bump_arena_allocator_with_marks_unit
// bump-pointer arena allocator with a stack of saved marks
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and gives exactly one
// result, shown on out_payload for one cycle with out_valid high; the receiver
// cannot stall it. Alloc, push, clear and a pop that drains the overflow count
// or underflows pass through the accept step, which latches and rounds the
// request, and the execute step, which does the add, compare and stack write,
// before the next possible accept; the result appears in the cycle after the
// execute step. A pop that restores a mark adds a step for the registered read
// of the mark memory. ALIGN_BYTES is a power of two. Capacity and base are
// written over the apb port at byte addresses 0 and 4; the user must write
// them only while idle, as the block itself does not enforce it.
module bump_arena_allocator_with_marks_unit
  import baa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_payload,
  output logic                   out_valid,
  output out_item_t              out_payload,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic [31:0] capacity;
  logic [31:0] base;
  ctrl_cmd_t   cmd;
  dp_stat_t    stat;

  baa_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity),
    .base     (base)
  );

  baa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  baa_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_payload  (in_payload),
    .capacity    (capacity),
    .base        (base),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

endmodule : bump_arena_allocator_with_marks_unit
`default_nettype wire

>>> test/tb_bump_arena_allocator_with_marks_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bump_arena_allocator_with_marks_unit
// self-checking bench for the bump arena allocator with its mark stack
// ----------------------------------------------------------------------------
// Commands are driven through the start/busy handshake. A behavioural copy of
// the allocator predicts the result of each accepted command. Every result
// beat is compared field by field with the oldest prediction. Capacity and
// base are changed over the apb port while the unit is idle, and each write
// is read back. The run covers:
//   - directed corners: rounding, address wrap and capacity below used bytes
//   - a full mark stack with overflow pushes counted and then drained
//   - random phases with different arena settings and sender idling
// ----------------------------------------------------------------------------
module tb_bump_arena_allocator_with_marks_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import baa_pkg::*;

  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 160;
  localparam int DRAIN_EVERY    = 150;
  localparam int OVF_PUSHES     = 6;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_payload;
  logic              out_valid;
  out_item_t         out_payload;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // predicted allocator state
  logic [31:0] pred_capacity;
  logic [31:0] pred_base;
  logic [31:0] pred_used;
  logic [31:0] pred_marks [MARK_DEPTH];
  int          pred_depth;
  int          pred_ovf;

  out_item_t   predicted_results [$];
  int          mismatch_count;
  int          sender_idle_pct;
  int          idle_cycles;

  always #1 clk = ~clk;

  bump_arena_allocator_with_marks_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_payload(out_payload),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %0d: %s expected %h got %h", mismatch_count, what, want, got);
    end
  endfunction

  function automatic out_item_t predict_arena_command(in_item_t it);
    out_item_t   res;
    logic [32:0] rounded;
    logic [33:0] total;
    res = '0;
    res.status = ST_OK;
    case (cmd_t'(it.command))
      CMD_ALLOC: begin
        rounded = ((33'(it.request_size) + 33'(ALIGN_BYTES - 1)) / 33'(ALIGN_BYTES))
                  * 33'(ALIGN_BYTES);
        total = 34'(pred_used) + 34'(rounded);
        if (total <= 34'(pred_capacity)) begin
          res.alloc_address = pred_base + pred_used;
          pred_used = pred_used + rounded[31:0];
        end else begin
          res.status = ST_OOM;
        end
      end
      CMD_PUSH: begin
        if (pred_depth < MARK_DEPTH) begin
          pred_marks[pred_depth] = pred_used;
          pred_depth++;
        end else begin
          if (pred_ovf < int'(OVF_MAX)) pred_ovf++;
          res.status = ST_OVF;
        end
      end
      CMD_POP: begin
        if (pred_ovf > 0) begin
          pred_ovf--;
        end else if (pred_depth > 0) begin
          pred_depth--;
          pred_used = pred_marks[pred_depth];
        end else begin
          res.status = ST_UNDER;
        end
      end
      default: begin
        pred_used  = '0;
        pred_depth = 0;
        pred_ovf   = 0;
      end
    endcase
    res.used_bytes = pred_used;
    res.mark_count = 7'(pred_depth);
    return res;
  endfunction

  function automatic in_item_t arena_cmd(cmd_t c, logic [31:0] size);
    in_item_t it;
    it.command      = c;
    it.request_size = size;
    return it;
  endfunction

  function automatic logic [31:0] random_request_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return $urandom_range(64);
    if (pick < 75) return $urandom_range(4096);
    if (pick < 85) return $urandom_range(pred_capacity);
    if (pick < 93) return $urandom();
    return 32'hFFFF_FFFF - $urandom_range(16);
  endfunction

  // segments lean towards pushes, then pops, so the stack fills and empties
  function automatic in_item_t random_arena_command(int idx);
    int unsigned pick;
    int          push_pct;
    int          pop_pct;
    pick = $urandom_range(99);
    case ((idx / 54) % 3)
      1:       begin push_pct = 45; pop_pct = 10; end
      2:       begin push_pct = 10; pop_pct = 45; end
      default: begin push_pct = 20; pop_pct = 22; end
    endcase
    if (pick < 2) return arena_cmd(CMD_CLEAR, $urandom());
    if (pick < 2 + push_pct) return arena_cmd(CMD_PUSH, $urandom());
    if (pick < 2 + push_pct + pop_pct) return arena_cmd(CMD_POP, $urandom());
    return arena_cmd(CMD_ALLOC, random_request_size());
  endfunction

  task automatic send_arena_command(input in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_payload <= it;
    do @(posedge clk); while (busy);
    predicted_results.push_back(predict_arena_command(it));
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_arena_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CAPACITY) pred_capacity = value;
    else pred_base = value;
    // read back
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) report_mismatch("register readback", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_arena(input logic [31:0] capacity, input logic [31:0] base);
    wait_results_drained();
    write_arena_reg(REG_CAPACITY, capacity);
    write_arena_reg(REG_BASE, base);
  endtask

  task automatic test_directed_corners();
    // reset settings: zero capacity still grants a zero-size alloc
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd0));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd1));
    send_arena_command(arena_cmd(CMD_POP, 32'd0));
    send_arena_command(arena_cmd(CMD_PUSH, 32'd0));
    send_arena_command(arena_cmd(CMD_POP, 32'd0));
    // full-range arena with a base that makes the address wrap
    set_arena(32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_arena_command(arena_cmd(CMD_ALLOC, 32'hFFFF_FFFF));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'hFFFF_FFF9));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd24));
    send_arena_command(arena_cmd(CMD_PUSH, 32'hFFFF_FFFF));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd16));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'hFFFF_FFC0));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'hFFFF_FFB7));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd24));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd7));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd0));
    send_arena_command(arena_cmd(CMD_POP, 32'hFFFF_FFFF));
    send_arena_command(arena_cmd(CMD_CLEAR, 32'hFFFF_FFFF));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd100));
    // capacity lowered below the bytes in use
    set_arena(32'd64, 32'h0000_0000);
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd0));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd8));
    send_arena_command(arena_cmd(CMD_PUSH, 32'd0));
    send_arena_command(arena_cmd(CMD_POP, 32'd0));
    send_arena_command(arena_cmd(CMD_CLEAR, 32'd0));
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd64));
  endtask

  task automatic test_mark_stack_saturation();
    set_arena(32'hFFFF_FFFF, 32'h0000_1000);
    send_arena_command(arena_cmd(CMD_CLEAR, 32'd0));
    for (int i = 0; i < MARK_DEPTH; i++) begin
      send_arena_command(arena_cmd(CMD_ALLOC, $urandom_range(200)));
      send_arena_command(arena_cmd(CMD_PUSH, $urandom()));
    end
    // pushes beyond a full stack are counted
    for (int i = 0; i < OVF_PUSHES; i++) begin
      send_arena_command(arena_cmd(CMD_PUSH, $urandom()));
    end
    send_arena_command(arena_cmd(CMD_ALLOC, 32'd40));
    for (int i = 0; i < OVF_PUSHES; i++) begin
      send_arena_command(arena_cmd(CMD_POP, $urandom()));
    end
    for (int i = 0; i <= MARK_DEPTH; i++) begin
      send_arena_command(arena_cmd(CMD_POP, $urandom()));
    end
    send_arena_command(arena_cmd(CMD_PUSH, 32'd0));
    send_arena_command(arena_cmd(CMD_CLEAR, 32'd0));
  endtask

  task automatic test_random_traffic(input int idle_pct, input logic [31:0] capacity,
                                     input logic [31:0] base);
    set_arena(capacity, base);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      send_arena_command(random_arena_command(i));
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) wait_results_drained();
    end
    sender_idle_pct = 0;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected beat, used bytes", 32'd0, out_payload.used_bytes);
      end else begin
        want = predicted_results.pop_front();
        if (out_payload.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_payload.status));
        if (out_payload.alloc_address !== want.alloc_address)
          report_mismatch("alloc address", want.alloc_address, out_payload.alloc_address);
        if (out_payload.used_bytes !== want.used_bytes)
          report_mismatch("used bytes", want.used_bytes, out_payload.used_bytes);
        if (out_payload.mark_count !== want.mark_count)
          report_mismatch("mark count", 32'(want.mark_count), 32'(out_payload.mark_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_bump_arena_allocator_with_marks_unit: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_payload      = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    pred_capacity   = '0;
    pred_base       = '0;
    pred_used       = '0;
    pred_depth      = 0;
    pred_ovf        = 0;
    foreach (pred_marks[i]) pred_marks[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_mark_stack_saturation();
    test_random_traffic(0,  $urandom_range(4096, 512), $urandom());
    test_random_traffic(64, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_random_traffic(0,  32'd0, $urandom());
    test_random_traffic(38, $urandom(), 32'h0000_0000);
    test_random_traffic(0,  $urandom_range(16384, 1024), 32'hFFFF_F000);
    test_random_traffic(64, $urandom_range(2048, 64), $urandom());
    test_random_traffic(0,  32'hFFFF_FFFF, 32'h0000_0000);
    test_random_traffic(38, $urandom(), $urandom());

    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("tb_bump_arena_allocator_with_marks_unit: PASS");
    end else begin
      $display("tb_bump_arena_allocator_with_marks_unit: FAIL");
    end
    $finish;
  end

endmodule : tb_bump_arena_allocator_with_marks_unit
`default_nettype wire

>>> bump_arena_allocator_with_marks_unit.f
src/baa_pkg.sv
src/baa_cfg.sv
src/baa_ctrl.sv
src/baa_dpath.sv
src/bump_arena_allocator_with_marks_unit.sv
test/tb_bump_arena_allocator_with_marks_unit.sv
